// ===== rtl/core/asm_source_tokenizer_macros.svh =====
// Assertion helpers for the tokenizer. Both sample on the rising edge of
// clock and are disabled while reset is high.
`ifndef ASM_SOURCE_TOKENIZER_MACROS_SVH
`define ASM_SOURCE_TOKENIZER_MACROS_SVH

// A property that must hold at every sampled edge.
`define TOK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TOK_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/asmtok_pkg.sv =====
`default_nettype none

package asmtok_pkg;

   // Token kind codes.
   localparam logic [5:0] KIND_PUNCT   = 6'd36;
   localparam logic [5:0] KIND_IDENT   = 6'd44;
   localparam logic [5:0] KIND_INTEGER = 6'd45;
   localparam logic [5:0] KIND_STRING  = 6'd46;
   localparam logic [5:0] KIND_END     = 6'd47;
   localparam logic [5:0] KIND_ILLEGAL = 6'd48;

   // Characters with a role of their own.
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SEMICOLON  = ";";
   localparam logic [7:0] CH_QUOTE      = "\"";
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_LOWER_A    = "a";
   localparam logic [7:0] CH_LOWER_Z    = "z";
   localparam logic [7:0] CH_UPPER_A    = "A";
   localparam logic [7:0] CH_UPPER_Z    = "Z";
   localparam logic [7:0] CH_DIGIT_0    = "0";
   localparam logic [7:0] CH_DIGIT_9    = "9";

   localparam int NUM_PUNCT = 8;
   localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{",", ":", "(", ")", "+", "-", "*", "/"};

   // Reserved names. The first character sits in the low byte, so each
   // literal is the name spelled backward and zero padded on the left.
   localparam int NAME_CMP_CHARS = 7;
   localparam int NAME_CMP_BITS  = 8 * NAME_CMP_CHARS;
   localparam int NUM_NAMES      = 36;
   localparam logic [NAME_CMP_BITS-1:0] NAME_TABLE [NUM_NAMES] = '{
      56'("vom"), 56'("pmj"), 56'("llac"), 56'("ter"), 56'("hsup"), 56'("pop"),
      56'("dda"), 56'("bus"), 56'("lum"), 56'("vid"), 56'("dom"), 56'("cni"),
      56'("ced"), 56'("pmc"), 56'("ej"), 56'("enj"), 56'("gj"), 56'("lj"),
      56'("noitces"), 56'("labolg"),
      56'("xar"), 56'("xbr"), 56'("xcr"), 56'("xdr"), 56'("psr"), 56'("pbr"),
      56'("isr"), 56'("idr"), 56'("8r"), 56'("9r"), 56'("01r"), 56'("11r"),
      56'("21r"), 56'("31r"), 56'("41r"), 56'("51r")
   };

   // Result slots of one character, in output order.
   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_CLOSE  = 0;
   localparam int SLOT_SINGLE = 1;
   localparam int SLOT_FLUSH  = 2;
   localparam int SLOT_END    = 3;
   localparam int MAX_RESULTS = 3;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_NUMBER  = 5'b00100,
      MODE_STRING  = 5'b01000,
      MODE_COMMENT = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      logic fire;
      logic final_beat;
   } scan_status_type;

   typedef struct packed {
      logic             room;
      logic [CNT_W-1:0] count;
   } queue_status_type;

   // Kind of an identifier: a reserved name when the text is short enough and
   // matches a table entry exactly, otherwise a plain identifier.
   function automatic logic [5:0] classify(input logic [NAME_CMP_BITS-1:0] prefix,
                                           input logic short_name);
      logic [5:0] kind;
      kind = KIND_IDENT;
      for (int i = 0; i < NUM_NAMES; i++) begin
         if (short_name && prefix == NAME_TABLE[i]) begin
            kind = 6'(i);
         end
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/asmtok_req_if.sv =====
`default_nettype none

interface asmtok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       final_char;

   modport source (output valid, output ch, output final_char, input ready);
   modport sink (input valid, input ch, input final_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/asmtok_rsp_if.sv =====
`default_nettype none

interface asmtok_rsp_if #(
   parameter int OFFSET_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [5:0]             token_kind;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [OFFSET_BITS-1:0] token_length;
   logic                   run_end;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output run_end, input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input token_length, input run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/asm_source_tokenizer.sv =====
`default_nettype none
`include "asm_source_tokenizer_macros.svh"

// Streaming lexer for assembly source text. Each req beat carries one
// character and a flag on the last character of a text; each rsp beat carries
// one token as kind, start offset and length, with run_end set on the last
// token that a character causes. A character is taken every cycle as long as
// the result side keeps up: it is held in the input register, scanned in a
// single pass and written into an eight-entry result queue, whose head entry
// offers its first token on the rsp port. A character may cause up to three
// tokens and the result port gives one per cycle while rsp ready is high; the
// input register holds a character until the queue has room for three, and
// while it holds one, req ready stays low, so a burst backs up into the input
// side once the queue has filled.
module asm_source_tokenizer #(
   parameter int OFFSET_BITS       = 16,
   parameter int NAME_BUFFER_CHARS = 7
) (
   input  logic          clock,
   input  logic          reset,
   asmtok_req_if.sink    req_bus,
   asmtok_rsp_if.source  rsp_bus
);
   import asmtok_pkg::*;

   logic [NUM_SLOTS-1:0]                  slot_valid;
   logic [NUM_SLOTS-1:0]                  slot_last;
   logic [NUM_SLOTS-1:0][5:0]             slot_kind;
   logic [NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_start;
   logic [NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_len;
   scan_status_type                       scan_status;
   queue_status_type                      q_status;

   // Character scanner with its input register.
   asmtok_scan #(
      .OFFSET_BITS       (OFFSET_BITS),
      .NAME_BUFFER_CHARS (NAME_BUFFER_CHARS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .room       (q_status.room),
      .slot_valid (slot_valid),
      .slot_last  (slot_last),
      .slot_kind  (slot_kind),
      .slot_start (slot_start),
      .slot_len   (slot_len),
      .status     (scan_status)
   );

   // Result queue feeding the rsp channel.
   asmtok_queue #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (slot_valid),
      .slot_last  (slot_last),
      .slot_kind  (slot_kind),
      .slot_start (slot_start),
      .slot_len   (slot_len),
      .rsp_bus    (rsp_bus),
      .status     (q_status)
   );

   // The queue never holds more entries than it has.
   `TOK_ASSERT(a_queue_bound, q_status.count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
   // One character never causes more tokens than the queue reserves.
   `TOK_ASSERT(a_burst_limit, $countones(slot_valid) <= MAX_RESULTS, "token burst too long")
   // The last character of a text always yields the end token.
   `TOK_ASSERT_IMP(a_end_token, scan_status.fire && scan_status.final_beat, slot_valid[SLOT_END], "end token missing")
   // No tokens are written without a scanned character.
   `TOK_ASSERT_IMP(a_no_stray, !scan_status.fire, slot_valid == '0, "token written while stalled")

endmodule

`default_nettype wire

// ===== rtl/core/asmtok_scan.sv =====
`default_nettype none

module asmtok_scan #(
   parameter int OFFSET_BITS       = 16,
   parameter int NAME_BUFFER_CHARS = 7
) (
   input  logic                                          clock,
   input  logic                                          reset,
   asmtok_req_if.sink                                    req_bus,
   input  logic                                          room,
   output logic [asmtok_pkg::NUM_SLOTS-1:0]              slot_valid,
   output logic [asmtok_pkg::NUM_SLOTS-1:0]              slot_last,
   output logic [asmtok_pkg::NUM_SLOTS-1:0][5:0]         slot_kind,
   output logic [asmtok_pkg::NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_start,
   output logic [asmtok_pkg::NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_len,
   output asmtok_pkg::scan_status_type                   status
);
   import asmtok_pkg::*;

   localparam int PREFIX_BITS = 8 * NAME_BUFFER_CHARS;
   localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);
   localparam logic [OFFSET_BITS-1:0] SHORT_MAX = OFFSET_BITS'(NAME_CMP_CHARS);

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] x);
      return (&x) ? x : x + ONE;
   endfunction

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] ch_ff, ch_in;
   logic       final_ff, final_in;

   // Scanner state.
   scan_mode_type          mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic [PREFIX_BITS-1:0] prefix_ff, prefix_in;

   logic fire;
   logic take;
   logic is_alpha, is_digit, is_word, is_space, is_punct;
   logic [2:0] punct_idx;
   logic consumed;

   // The input register frees up whenever its beat moves into the queue.
   assign fire          = in_valid_ff && room;
   assign req_bus.ready = !in_valid_ff || room;
   assign take          = req_bus.valid && req_bus.ready;

   assign in_valid_in = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign ch_in       = take ? req_bus.ch : ch_ff;
   assign final_in    = take ? req_bus.final_char : final_ff;

   assign status.fire       = fire;
   assign status.final_beat = final_ff;

   // Character classes.
   always_comb begin
      is_alpha = (ch_ff >= CH_LOWER_A && ch_ff <= CH_LOWER_Z) ||
                 (ch_ff >= CH_UPPER_A && ch_ff <= CH_UPPER_Z);
      is_digit = ch_ff >= CH_DIGIT_0 && ch_ff <= CH_DIGIT_9;
      is_word  = is_alpha || is_digit || ch_ff == CH_UNDERSCORE;
      is_space = ch_ff == CH_SPACE || (ch_ff >= CH_TAB && ch_ff <= CH_CR);
      is_punct  = 1'b0;
      punct_idx = 3'd0;
      for (int i = 0; i < NUM_PUNCT; i++) begin
         if (ch_ff == PUNCT_CHARS[i]) begin
            is_punct  = 1'b1;
            punct_idx = 3'(i);
         end
      end
   end

   // One character: close the open token, handle the character, then flush
   // at the end of the text.
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      prefix_in  = prefix_ff;
      consumed   = 1'b0;
      slot_valid = '0;
      slot_kind  = '0;
      slot_start = '0;
      slot_len   = '0;

      if (fire) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_word) begin
                  for (int j = 0; j < NAME_BUFFER_CHARS; j++) begin
                     if (count_ff == OFFSET_BITS'(j)) begin
                        prefix_in[8*j +: 8] = ch_ff;
                     end
                  end
                  count_in = sat_inc(count_ff);
                  consumed = 1'b1;
               end else begin
                  slot_valid[SLOT_CLOSE] = 1'b1;
                  slot_kind[SLOT_CLOSE]  = classify(prefix_ff[NAME_CMP_BITS-1:0],
                                                    count_ff <= SHORT_MAX);
                  slot_start[SLOT_CLOSE] = start_ff;
                  slot_len[SLOT_CLOSE]   = count_ff;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  count_in = sat_inc(count_ff);
                  consumed = 1'b1;
               end else begin
                  slot_valid[SLOT_CLOSE] = 1'b1;
                  slot_kind[SLOT_CLOSE]  = KIND_INTEGER;
                  slot_start[SLOT_CLOSE] = start_ff;
                  slot_len[SLOT_CLOSE]   = count_ff;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               consumed = 1'b1;
               if (ch_ff == CH_QUOTE) begin
                  slot_valid[SLOT_CLOSE] = 1'b1;
                  slot_kind[SLOT_CLOSE]  = KIND_STRING;
                  slot_start[SLOT_CLOSE] = start_ff;
                  slot_len[SLOT_CLOSE]   = count_ff;
                  mode_in = MODE_IDLE;
               end else begin
                  count_in = sat_inc(count_ff);
               end
            end
            MODE_COMMENT: begin
               consumed = 1'b1;
               if (ch_ff == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         // A character not taken by an open token is handled as in idle.
         if (!consumed) begin
            if (is_space) begin
               mode_in = mode_in;
            end else if (ch_ff == CH_SEMICOLON) begin
               mode_in = MODE_COMMENT;
            end else if (is_punct) begin
               slot_valid[SLOT_SINGLE] = 1'b1;
               slot_kind[SLOT_SINGLE]  = KIND_PUNCT + 6'(punct_idx);
               slot_start[SLOT_SINGLE] = pos_ff;
               slot_len[SLOT_SINGLE]   = ONE;
            end else if (is_alpha || ch_ff == CH_UNDERSCORE) begin
               mode_in   = MODE_IDENT;
               start_in  = pos_ff;
               count_in  = ONE;
               prefix_in = '0;
               prefix_in[7:0] = ch_ff;
            end else if (is_digit) begin
               mode_in  = MODE_NUMBER;
               start_in = pos_ff;
               count_in = ONE;
            end else if (ch_ff == CH_QUOTE) begin
               mode_in  = MODE_STRING;
               start_in = sat_inc(pos_ff);
               count_in = '0;
            end else begin
               slot_valid[SLOT_SINGLE] = 1'b1;
               slot_kind[SLOT_SINGLE]  = KIND_ILLEGAL;
               slot_start[SLOT_SINGLE] = pos_ff;
               slot_len[SLOT_SINGLE]   = ONE;
            end
         end

         // End of text: emit the open token and the end marker, then restart.
         if (final_ff) begin
            slot_start[SLOT_FLUSH] = start_in;
            slot_len[SLOT_FLUSH]   = count_in;
            case (mode_in)
               MODE_IDENT: begin
                  slot_valid[SLOT_FLUSH] = 1'b1;
                  slot_kind[SLOT_FLUSH]  = classify(prefix_in[NAME_CMP_BITS-1:0],
                                                    count_in <= SHORT_MAX);
               end
               MODE_NUMBER: begin
                  slot_valid[SLOT_FLUSH] = 1'b1;
                  slot_kind[SLOT_FLUSH]  = KIND_INTEGER;
               end
               MODE_STRING: begin
                  slot_valid[SLOT_FLUSH] = 1'b1;
                  slot_kind[SLOT_FLUSH]  = KIND_STRING;
               end
               default: begin
                  slot_valid[SLOT_FLUSH] = 1'b0;
               end
            endcase
            slot_valid[SLOT_END] = 1'b1;
            slot_kind[SLOT_END]  = KIND_END;
            slot_start[SLOT_END] = sat_inc(pos_ff);
            slot_len[SLOT_END]   = '0;
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            start_in  = '0;
            count_in  = '0;
            prefix_in = '0;
         end else begin
            pos_in = sat_inc(pos_ff);
         end
      end
   end

   // Mark the last token that this character causes.
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_last[k] = slot_valid[k];
         for (int m = k + 1; m < NUM_SLOTS; m++) begin
            if (slot_valid[m]) begin
               slot_last[k] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         start_ff    <= '0;
         count_ff    <= '0;
         prefix_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         count_ff    <= count_in;
         prefix_ff   <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      final_ff <= final_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/asmtok_queue.sv =====
`default_nettype none

module asmtok_queue #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [asmtok_pkg::NUM_SLOTS-1:0]                  slot_valid,
   input  logic [asmtok_pkg::NUM_SLOTS-1:0]                  slot_last,
   input  logic [asmtok_pkg::NUM_SLOTS-1:0][5:0]             slot_kind,
   input  logic [asmtok_pkg::NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_start,
   input  logic [asmtok_pkg::NUM_SLOTS-1:0][OFFSET_BITS-1:0] slot_len,
   asmtok_rsp_if.source                                      rsp_bus,
   output asmtok_pkg::queue_status_type                      status
);
   import asmtok_pkg::*;

   logic [5:0]             kind_ff  [FIFO_DEPTH];
   logic [OFFSET_BITS-1:0] start_ff [FIFO_DEPTH];
   logic [OFFSET_BITS-1:0] len_ff   [FIFO_DEPTH];
   logic                   last_ff  [FIFO_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [NUM_SLOTS-1:0][PTR_W-1:0] wr_idx;
   logic [2:0] num_wr;
   logic       pop;

   // Valid slots are packed into consecutive entries from the tail.
   always_comb begin
      num_wr = 3'd0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         wr_idx[k] = tail_ff + PTR_W'(num_wr);
         num_wr    = num_wr + 3'(slot_valid[k]);
      end
   end

   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign head_in  = head_ff + PTR_W'(pop);
   assign tail_in  = tail_ff + PTR_W'(num_wr);
   assign count_in = count_ff + CNT_W'(num_wr) - CNT_W'(pop);

   // Room for the largest burst one character can cause.
   assign status.room  = count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);
   assign status.count = count_ff;

   // Head entry drives the result channel.
   assign rsp_bus.valid        = count_ff != '0;
   assign rsp_bus.token_kind   = kind_ff[head_ff];
   assign rsp_bus.start_offset = start_ff[head_ff];
   assign rsp_bus.token_length = len_ff[head_ff];
   assign rsp_bus.run_end      = last_ff[head_ff];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (slot_valid[k]) begin
            kind_ff[wr_idx[k]]  <= slot_kind[k];
            start_ff[wr_idx[k]] <= slot_start[k];
            len_ff[wr_idx[k]]   <= slot_len[k];
            last_ff[wr_idx[k]]  <= slot_last[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/asm_source_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module asm_source_tokenizer_tb;
   import asmtok_pkg::*;

   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          DRAIN_CYCLES = 24;
   localparam int          RANDOM_CHARS = 450;
   localparam int          HOLD_AT      = 40;
   localparam int          HOLD_CYCLES  = 400;
   localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;
   localparam logic [7:0]  CH_VTAB      = 8'h0B;
   localparam logic [7:0]  CH_FORMFEED  = 8'h0C;

   // One source character as the driver offers it, with the idle cycles before it.
   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
      logic [3:0] gap;
   } source_char_type;

   // One token as the block should report it.
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic        run_end;
   } token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   asmtok_req_if req_bus ();
   asmtok_rsp_if #(.OFFSET_BITS(16)) rsp_bus ();

   asm_source_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // Testbench side of both channels, known from time zero.
   logic       tx_valid = 1'b0;
   logic [7:0] tx_ch    = '0;
   logic       tx_last  = 1'b0;
   logic       rx_ready = 1'b0;

   assign req_bus.valid      = tx_valid;
   assign req_bus.ch         = tx_ch;
   assign req_bus.final_char = tx_last;
   assign rsp_bus.ready      = rx_ready;

   source_char_type source_text[$];
   token_type       pending_tokens[$];

   int  mismatch_count = 0;
   int  chars_accepted = 0;
   int  tokens_seen    = 0;
   int  texts_built    = 0;
   int  cycle_count    = 0;
   int  tx_wait        = 0;
   int  rx_wait        = 0;
   bit  tx_busy;
   bit  tx_calm        = 1'b0;
   bit  rx_calm        = 1'b0;

   // Lexer state as the block should hold it.
   scan_mode_type            lex_mode   = MODE_IDLE;
   logic [15:0]              lex_pos    = '0;
   logic [15:0]              lex_start  = '0;
   logic [15:0]              lex_count  = '0;
   logic [NAME_CMP_BITS-1:0] lex_prefix = '0;

   function automatic logic [15:0] sat_inc(input logic [15:0] x);
      return (x == OFFSET_MAX) ? x : x + 16'd1;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic token_type make_token(input logic [5:0] kind, input logic [15:0] start,
                                            input logic [15:0] len);
      token_type t;
      t.kind    = kind;
      t.start   = start;
      t.len     = len;
      t.run_end = 1'b0;
      return t;
   endfunction

   // A short identifier that matches a reserved name takes that name's kind.
   function automatic logic [5:0] name_kind();
      logic [5:0] kind;
      kind = KIND_IDENT;
      if (lex_count != 0 && lex_count <= NAME_CMP_CHARS) begin
         for (int i = 0; i < NUM_NAMES; i++) begin
            if (lex_prefix == NAME_TABLE[i]) begin
               kind = 6'(i);
            end
         end
      end
      return kind;
   endfunction

   // Advance the lexer by one character and queue the tokens it produces.
   task automatic scan_char(input logic [7:0] c, input logic last);
      token_type   found[$];
      logic        taken;
      logic        done;
      logic [15:0] pos;
      pos   = lex_pos;
      taken = 1'b0;
      done  = 1'b0;

      // An open token either absorbs the character or closes.
      case (lex_mode)
         MODE_IDENT: begin
            if (is_word(c)) begin
               if (lex_count < NAME_CMP_CHARS) begin
                  lex_prefix[8*lex_count +: 8] = c;
               end
               lex_count = sat_inc(lex_count);
               taken = 1'b1;
            end else begin
               found.push_back(make_token(name_kind(), lex_start, lex_count));
               lex_mode = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               lex_count = sat_inc(lex_count);
               taken = 1'b1;
            end else begin
               found.push_back(make_token(KIND_INTEGER, lex_start, lex_count));
               lex_mode = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (c == CH_QUOTE) begin
               found.push_back(make_token(KIND_STRING, lex_start, lex_count));
               lex_mode = MODE_IDLE;
            end else begin
               lex_count = sat_inc(lex_count);
            end
            taken = 1'b1;
         end
         MODE_COMMENT: begin
            if (c == CH_NEWLINE) begin
               lex_mode = MODE_IDLE;
            end
            taken = 1'b1;
         end
         default: begin
            lex_mode = MODE_IDLE;
         end
      endcase

      // A character not absorbed is handled as in idle mode.
      if (!taken) begin
         if (is_space(c)) begin
            done = 1'b1;
         end else if (c == CH_SEMICOLON) begin
            lex_mode = MODE_COMMENT;
            done = 1'b1;
         end
         for (int i = 0; i < NUM_PUNCT; i++) begin
            if (!done && c == PUNCT_CHARS[i]) begin
               found.push_back(make_token(KIND_PUNCT + 6'(i), pos, 16'd1));
               done = 1'b1;
            end
         end
         if (!done) begin
            if (is_letter(c) || c == CH_UNDERSCORE) begin
               lex_mode   = MODE_IDENT;
               lex_start  = pos;
               lex_count  = 16'd1;
               lex_prefix = '0;
               lex_prefix[7:0] = c;
            end else if (is_digit(c)) begin
               lex_mode  = MODE_NUMBER;
               lex_start = pos;
               lex_count = 16'd1;
            end else if (c == CH_QUOTE) begin
               lex_mode  = MODE_STRING;
               lex_start = sat_inc(pos);
               lex_count = '0;
            end else begin
               found.push_back(make_token(KIND_ILLEGAL, pos, 16'd1));
            end
         end
      end

      // The last character flushes the open token, reports the end and clears state.
      if (last) begin
         if (lex_mode == MODE_IDENT) begin
            found.push_back(make_token(name_kind(), lex_start, lex_count));
         end else if (lex_mode == MODE_NUMBER) begin
            found.push_back(make_token(KIND_INTEGER, lex_start, lex_count));
         end else if (lex_mode == MODE_STRING) begin
            found.push_back(make_token(KIND_STRING, lex_start, lex_count));
         end
         found.push_back(make_token(KIND_END, sat_inc(pos), '0));
         lex_mode   = MODE_IDLE;
         lex_pos    = '0;
         lex_start  = '0;
         lex_count  = '0;
         lex_prefix = '0;
      end else begin
         lex_pos = sat_inc(pos);
      end

      if (found.size() > 0) begin
         found[found.size()-1].run_end = 1'b1;
      end
      foreach (found[i]) begin
         pending_tokens.push_back(found[i]);
      end
   endtask

   // Text building.
   task automatic put_char(input logic [7:0] c);
      source_char_type s;
      s.ch        = c;
      s.last_char = 1'b0;
      s.gap       = tx_calm ? 4'd0 : 4'($urandom_range(0, 15));
      source_text.push_back(s);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         put_char(s[i]);
      end
   endtask

   task automatic mark_last();
      source_text[source_text.size()-1].last_char = 1'b1;
      texts_built++;
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return CH_LOWER_A + 8'(r);
      else if (r < 52) return CH_UPPER_A + 8'(r - 26);
      return CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_word_char();
      if ($urandom_range(0, 5) == 0) return CH_DIGIT_0 + 8'($urandom_range(0, 9));
      return rand_letter();
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(0, 5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_NEWLINE;
         3:       return CH_VTAB;
         4:       return CH_FORMFEED;
         default: return CH_CR;
      endcase
   endfunction

   // One token of a well-formed line, sometimes slightly off.
   task automatic put_random_token();
      int                       pick;
      int                       n;
      int                       idx;
      logic [NAME_CMP_BITS-1:0] word;
      logic [7:0]               c;
      bit                       upper;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // Reserved name, now and then capitalized or lengthened.
         idx   = $urandom_range(0, NUM_NAMES - 1);
         word  = NAME_TABLE[idx];
         upper = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < NAME_CMP_CHARS; k++) begin
            c = word[8*k +: 8];
            if (c != 8'd0) begin
               if (upper && k == 0 && is_letter(c)) c = c ^ 8'h20;
               put_char(c);
            end
         end
         if ($urandom_range(0, 7) == 0) put_char(rand_word_char());
      end else if (pick < 45) begin
         n = $urandom_range(1, 12);
         put_char(rand_letter());
         for (int k = 1; k < n; k++) put_char(rand_word_char());
      end else if (pick < 55) begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) put_char(CH_DIGIT_0 + 8'($urandom_range(0, 9)));
      end else if (pick < 65) begin
         // String with arbitrary bytes inside; a few stay open.
         put_char(CH_QUOTE);
         n = $urandom_range(0, 8);
         for (int k = 0; k < n; k++) begin
            c = 8'($urandom_range(0, 255));
            put_char(c == CH_QUOTE ? CH_UNDERSCORE : c);
         end
         if ($urandom_range(0, 9) != 0) put_char(CH_QUOTE);
      end else if (pick < 73) begin
         put_char(CH_SEMICOLON);
         n = $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            c = 8'($urandom_range(0, 255));
            put_char(c == CH_NEWLINE ? CH_SPACE : c);
         end
         if ($urandom_range(0, 9) != 0) put_char(CH_NEWLINE);
      end else if (pick < 88) begin
         put_char(PUNCT_CHARS[$urandom_range(0, NUM_PUNCT - 1)]);
      end else begin
         put_char(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic put_random_text();
      int n;
      tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // Noise: raw bytes of any value.
         n = $urandom_range(1, 8);
         for (int k = 0; k < n; k++) put_char(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 10);
         for (int k = 0; k < n; k++) begin
            put_random_token();
            if (k < n - 1 && $urandom_range(0, 3) != 0) begin
               repeat ($urandom_range(1, 3)) put_char(rand_space());
            end
         end
      end
      mark_last();
   endtask

   // Driver: one character beat at a time, each after its own idle gap.
   always @(posedge clock) begin
      if (reset) begin
         tx_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         tx_busy = tx_valid;
         if (tx_valid && req_bus.ready) begin
            scan_char(tx_ch, tx_last);
            chars_accepted++;
            tx_busy = 1'b0;
            if (source_text.size() > 0) tx_wait = source_text[0].gap;
         end
         if (!tx_busy && source_text.size() > 0) begin
            if (tx_wait == 0) begin
               tx_valid <= 1'b1;
               tx_ch    <= source_text[0].ch;
               tx_last  <= source_text[0].last_char;
               void'(source_text.pop_front());
               tx_busy = 1'b1;
            end else begin
               tx_wait--;
            end
         end
         if (!tx_busy) tx_valid <= 1'b0;
      end
   end

   // Monitor: check each token beat against the oldest expectation, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rx_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_bus.valid && rx_ready) begin
            if (pending_tokens.size() == 0) begin
               $error("token beat with no expectation: kind %0d start %0d length %0d",
                      rsp_bus.token_kind, rsp_bus.start_offset, rsp_bus.token_length);
               mismatch_count++;
            end else begin
               if (rsp_bus.token_kind !== pending_tokens[0].kind) begin
                  $error("token_kind: expected %0d, got %0d",
                         pending_tokens[0].kind, rsp_bus.token_kind);
                  mismatch_count++;
               end
               if (rsp_bus.start_offset !== pending_tokens[0].start) begin
                  $error("start_offset: expected %0d, got %0d",
                         pending_tokens[0].start, rsp_bus.start_offset);
                  mismatch_count++;
               end
               if (rsp_bus.token_length !== pending_tokens[0].len) begin
                  $error("token_length: expected %0d, got %0d",
                         pending_tokens[0].len, rsp_bus.token_length);
                  mismatch_count++;
               end
               if (rsp_bus.run_end !== pending_tokens[0].run_end) begin
                  $error("run_end: expected %0d, got %0d",
                         pending_tokens[0].run_end, rsp_bus.run_end);
                  mismatch_count++;
               end
               void'(pending_tokens.pop_front());
            end
            tokens_seen++;
            if (tokens_seen % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            // One long hold lets the result queue fill and back up the input.
            if (tokens_seen == HOLD_AT) rx_wait = HOLD_CYCLES;
            else rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rx_ready <= (rx_wait == 0);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int base;

      // Directed: reserved names closed by space and comma, NUL and a high byte,
      // an over-long identifier closed by a string, a comment, a number closed by a
      // quote, and a last character that leaves a string open.
      put_text("mov r15,");
      put_char(8'h00);
      put_char(8'hFF);
      put_text("globalx7\"a\"");
      put_char(CH_SEMICOLON);
      put_char("x");
      put_char(CH_NEWLINE);
      put_text("42\"u");
      mark_last();

      // Random lines of mostly well-formed source.
      base = source_text.size();
      while (source_text.size() - base < RANDOM_CHARS) put_random_text();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (source_text.size() != 0 || tx_valid) @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scanned %0d characters in %0d texts and checked %0d tokens,",
               chars_accepted, texts_built, tokens_seen);
      $display("including names, numbers, strings, comments, odd bytes and a %0d-cycle stall.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/asmtok_pkg.sv
rtl/core/asmtok_req_if.sv
rtl/core/asmtok_rsp_if.sv
rtl/core/asmtok_scan.sv
rtl/core/asmtok_queue.sv
rtl/core/asm_source_tokenizer.sv
tb/asm_source_tokenizer_tb.sv
